// File: hdl/mr_pkg.sv
// ----------------------------------------------------------------------------
// mr_pkg
// Shared types for the Miller-Rabin witness round: beat structs, decision
// codes and the microcode program that drives the sequencer.
// ----------------------------------------------------------------------------
package mr_pkg;

  typedef struct packed {
    logic [31:0] candidate;
    logic [31:0] witness;
  } in_beat_t;

  typedef struct packed {
    logic       probably_prime;
    logic [1:0] how_decided;
  } out_beat_t;

  localparam logic [1:0] HOW_ROUND = 2'd0;
  localparam logic [1:0] HOW_SMALL = 2'd1;
  localparam logic [1:0] HOW_RANGE = 2'd2;

  typedef logic [4:0] upc_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_STRIP,
    DP_INIT,
    DP_MUL_GO,
    DP_SQB_GO,
    DP_SQX_GO,
    DP_WB_ACC,
    DP_WB_BASE,
    DP_SHIFT,
    DP_SET_PRIME,
    DP_SET_COMP,
    DP_PRIME_INC,
    DP_PUSH
  } dp_op_t;

  typedef enum logic [3:0] {
    COND_NONE,
    COND_JUMP,
    COND_ACCEPT,
    COND_D_EVEN,
    COND_D_ZERO,
    COND_MM_WAIT,
    COND_X_HIT,
    COND_X_ONE,
    COND_X_NM1,
    COND_I_GE_R,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    dp_op_t dp;
    cond_t  cond;
    upc_t   target;
  } ucode_t;

  localparam upc_t P_IDLE  = 5'd0;
  localparam upc_t P_STRIP = 5'd1;
  localparam upc_t P_INIT  = 5'd2;
  localparam upc_t P_TEST  = 5'd3;
  localparam upc_t P_BIT   = 5'd4;
  localparam upc_t P_MUL   = 5'd5;
  localparam upc_t P_MULW  = 5'd6;
  localparam upc_t P_SQ    = 5'd7;
  localparam upc_t P_SQW   = 5'd8;
  localparam upc_t P_SHIFT = 5'd9;
  localparam upc_t P_CHECK = 5'd10;
  localparam upc_t P_LOOP  = 5'd11;
  localparam upc_t P_SQX   = 5'd12;
  localparam upc_t P_SQXW  = 5'd13;
  localparam upc_t P_EV1   = 5'd14;
  localparam upc_t P_EVN   = 5'd15;
  localparam upc_t P_BACK  = 5'd16;
  localparam upc_t P_DONE  = 5'd17;

  function automatic ucode_t ucode_rom(input upc_t addr);
    ucode_t w;
    case (addr)
      P_IDLE:  w = '{dp: DP_LOAD,      cond: COND_ACCEPT,   target: P_DONE};
      P_STRIP: w = '{dp: DP_STRIP,     cond: COND_D_EVEN,   target: P_STRIP};
      P_INIT:  w = '{dp: DP_INIT,      cond: COND_NONE,     target: P_IDLE};
      P_TEST:  w = '{dp: DP_NOP,       cond: COND_D_ZERO,   target: P_CHECK};
      P_BIT:   w = '{dp: DP_NOP,       cond: COND_D_EVEN,   target: P_SQ};
      P_MUL:   w = '{dp: DP_MUL_GO,    cond: COND_NONE,     target: P_IDLE};
      P_MULW:  w = '{dp: DP_WB_ACC,    cond: COND_MM_WAIT,  target: P_IDLE};
      P_SQ:    w = '{dp: DP_SQB_GO,    cond: COND_NONE,     target: P_IDLE};
      P_SQW:   w = '{dp: DP_WB_BASE,   cond: COND_MM_WAIT,  target: P_IDLE};
      P_SHIFT: w = '{dp: DP_SHIFT,     cond: COND_JUMP,     target: P_TEST};
      P_CHECK: w = '{dp: DP_SET_PRIME, cond: COND_X_HIT,    target: P_DONE};
      P_LOOP:  w = '{dp: DP_SET_COMP,  cond: COND_I_GE_R,   target: P_DONE};
      P_SQX:   w = '{dp: DP_SQX_GO,    cond: COND_NONE,     target: P_IDLE};
      P_SQXW:  w = '{dp: DP_WB_ACC,    cond: COND_MM_WAIT,  target: P_IDLE};
      P_EV1:   w = '{dp: DP_NOP,       cond: COND_X_ONE,    target: P_DONE};
      P_EVN:   w = '{dp: DP_PRIME_INC, cond: COND_X_NM1,    target: P_DONE};
      P_BACK:  w = '{dp: DP_NOP,       cond: COND_JUMP,     target: P_LOOP};
      P_DONE:  w = '{dp: DP_PUSH,      cond: COND_OUT_FREE, target: P_IDLE};
      default: w = '{dp: DP_NOP,       cond: COND_JUMP,     target: P_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/mr_modmul.sv
// ----------------------------------------------------------------------------
// mr_modmul
// Bit-serial modular multiplier: result = x * y mod m, one bit of y per
// cycle, most significant first, with both operands already below m.
// ----------------------------------------------------------------------------
module mr_modmul #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] op_x,
  input  logic [W-1:0] op_y,
  input  logic [W-1:0] modulus,
  output logic         done,
  output logic [W-1:0] result
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  acc_r, x_r, y_r, m_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [W+1:0]  sum, m1, m2, red;

  always_comb begin
    m1  = {2'b00, m_r};
    m2  = {1'b0, m_r, 1'b0};
    sum = {1'b0, acc_r, 1'b0} + (y_r[W-1] ? {2'b00, x_r} : '0);
    if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      x_r   <= op_x;
      y_r   <= op_y;
      m_r   <= modulus;
    end else if (busy_r) begin
      acc_r <= red[W-1:0];
      y_r   <= {y_r[W-2:0], 1'b0};
    end
  end

  assign done   = done_r;
  assign result = acc_r;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("multiply started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while still busy");
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (acc_r < m_r)) else $error("product not reduced");
`endif

endmodule

// File: hdl/miller_rabin_witness_test.sv
// ----------------------------------------------------------------------------
// miller_rabin_witness_test
// One Miller-Rabin round per beat: candidate n and witness a in, verdict out.
//
// Input beat (in_valid/in_ready): candidate and witness, low NUM_WIDTH bits
// used. Output beat (out_valid/out_ready): probably_prime and how_decided
// (witness round, small-case rule, or witness out of range).
// A microcode sequencer works on one beat at a time; in_ready is high only
// while it waits at its first step. Small candidates and out-of-range
// witnesses go from the first step straight to the last. A witness round
// strips factors of two from n-1, then per exponent bit does a square,
// plus a multiply when the bit is set, on the bit-serial modular
// multiplier, then the trailing squarings.
// The verdict goes to an output register, so the next beat is accepted
// while a stalled result waits; the sequencer only holds at its last step
// if a second verdict is ready before the first is taken.
// Reset (rst_n low, synchronous) returns the sequencer to its first step
// and empties the output register.
// ----------------------------------------------------------------------------
module miller_rabin_witness_test #(
  parameter int NUM_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mr_pkg::in_beat_t  in_beat,
  output logic              out_valid,
  input  logic              out_ready,
  output mr_pkg::out_beat_t out_beat
);

  localparam int W  = NUM_WIDTH;
  localparam int RW = $clog2(W);

  mr_pkg::upc_t      upc_r, upc_nxt;
  mr_pkg::ucode_t    uc;
  mr_pkg::out_beat_t out_r;
  logic              out_valid_r;

  logic [W-1:0]  n_r, nm1_r, base_r, acc_r, d_r;
  logic [RW-1:0] r_r, i_r;
  logic          prime_r;
  logic [1:0]    how_r;

  logic [W-1:0] in_n, in_a, in_nm2;
  logic         accept, early, early_prime;
  logic [1:0]   early_how;
  logic         take, hold;
  logic         x_one, x_nm1, out_free;

  logic         mm_start, mm_done;
  logic [W-1:0] mm_x, mm_y, mm_res;

  assign uc       = mr_pkg::ucode_rom(upc_r);
  assign in_ready = (upc_r == mr_pkg::P_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_n     = in_beat.candidate[W-1:0];
  assign in_a     = in_beat.witness[W-1:0];
  assign in_nm2   = in_n - W'(2);
  assign x_one    = (acc_r == W'(1));
  assign x_nm1    = (acc_r == nm1_r);
  assign out_free = !out_valid_r || out_ready;

  // early verdicts
  always_comb begin
    early       = 1'b1;
    early_prime = 1'b0;
    early_how   = mr_pkg::HOW_SMALL;
    if (in_n <= W'(1) || in_n == W'(4)) begin
      early_prime = 1'b0;
    end else if (in_n <= W'(3)) begin
      early_prime = 1'b1;
    end else if (in_a < W'(2) || in_a > in_nm2) begin
      early_how = mr_pkg::HOW_RANGE;
    end else begin
      early     = 1'b0;
      early_how = mr_pkg::HOW_ROUND;
    end
  end

  // sequencer branch logic
  always_comb begin
    take = 1'b0;
    hold = 1'b0;
    case (uc.cond)
      mr_pkg::COND_NONE:     take = 1'b0;
      mr_pkg::COND_JUMP:     take = 1'b1;
      mr_pkg::COND_ACCEPT: begin
        hold = !accept;
        take = early;
      end
      mr_pkg::COND_D_EVEN:   take = !d_r[0];
      mr_pkg::COND_D_ZERO:   take = (d_r == '0);
      mr_pkg::COND_MM_WAIT:  hold = !mm_done;
      mr_pkg::COND_X_HIT:    take = x_one || x_nm1;
      mr_pkg::COND_X_ONE:    take = x_one;
      mr_pkg::COND_X_NM1:    take = x_nm1;
      mr_pkg::COND_I_GE_R:   take = (i_r >= r_r);
      mr_pkg::COND_OUT_FREE: begin
        hold = !out_free;
        take = 1'b1;
      end
      default:               take = 1'b1;
    endcase
    if (hold) begin
      upc_nxt = upc_r;
    end else if (take) begin
      upc_nxt = uc.target;
    end else begin
      upc_nxt = upc_r + 1'b1;
    end
  end

  // multiplier operand select
  always_comb begin
    mm_start = 1'b0;
    mm_x     = acc_r;
    mm_y     = base_r;
    case (uc.dp)
      mr_pkg::DP_MUL_GO: mm_start = 1'b1;
      mr_pkg::DP_SQB_GO: begin
        mm_start = 1'b1;
        mm_x     = base_r;
      end
      mr_pkg::DP_SQX_GO: begin
        mm_start = 1'b1;
        mm_y     = acc_r;
      end
      default:           mm_start = 1'b0;
    endcase
  end

  mr_modmul #(
    .W(W)
  ) u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mm_start),
    .op_x    (mm_x),
    .op_y    (mm_y),
    .modulus (n_r),
    .done    (mm_done),
    .result  (mm_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= mr_pkg::P_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      upc_r <= upc_nxt;
      if (uc.dp == mr_pkg::DP_PUSH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (uc.dp)
      mr_pkg::DP_LOAD: begin
        if (accept) begin
          n_r     <= in_n;
          nm1_r   <= in_n - W'(1);
          d_r     <= in_n - W'(1);
          base_r  <= in_a;
          r_r     <= '0;
          prime_r <= early_prime;
          how_r   <= early_how;
        end
      end
      mr_pkg::DP_STRIP: begin
        if (!d_r[0]) begin
          d_r <= d_r >> 1;
          r_r <= r_r + 1'b1;
        end
      end
      mr_pkg::DP_INIT: begin
        acc_r <= W'(1);
        i_r   <= RW'(1);
      end
      mr_pkg::DP_WB_ACC: begin
        if (mm_done) begin
          acc_r <= mm_res;
        end
      end
      mr_pkg::DP_WB_BASE: begin
        if (mm_done) begin
          base_r <= mm_res;
        end
      end
      mr_pkg::DP_SHIFT:     d_r <= d_r >> 1;
      mr_pkg::DP_SET_PRIME: prime_r <= 1'b1;
      mr_pkg::DP_SET_COMP:  prime_r <= 1'b0;
      mr_pkg::DP_PRIME_INC: begin
        prime_r <= 1'b1;
        i_r     <= i_r + 1'b1;
      end
      mr_pkg::DP_PUSH: begin
        if (out_free) begin
          out_r.probably_prime <= prime_r;
          out_r.how_decided    <= how_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

`ifndef SYNTHESIS
  a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r <= mr_pkg::P_DONE) else $error("sequencer left its program");
  a_early_done: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && early) |=> (upc_r == mr_pkg::P_DONE))
    else $error("early verdict did not go straight to done");
  a_push_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(upc_r == mr_pkg::P_DONE))
    else $error("result raised outside done step");
  a_round_how: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == mr_pkg::P_CHECK) |-> (how_r == mr_pkg::HOW_ROUND))
    else $error("witness round with wrong decision code");
`endif

endmodule
